// ===== rtl/plac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plac_pkg
// Shared constants, register codes, payload types and pipeline depths for the
// pixel linearize and alpha convert unit.
// ----------------------------------------------------------------------------
package plac_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int CHANNEL_BITS = 16;
    localparam int ALPHA_BITS   = FRAC_BITS + 1;
    localparam int ALPHA_ONE    = 1 << FRAC_BITS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OPERATION      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_IS_SRGB  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_IS_PREM = 2'd2;

    localparam logic [1:0] OP_LINEARIZE   = 2'd0;
    localparam logic [1:0] OP_TO_PREMUL   = 2'd1;
    localparam logic [1:0] OP_TO_STRAIGHT = 2'd2;

    // sRGB curve arithmetic works in unsigned Q.20.
    localparam int WB         = 20;
    localparam int SRGB_OFF   = 57672;     // 0.055 in Q.20
    localparam int SRGB_DIV   = 1106248;   // 1.055 in Q.20
    localparam int SRGB_DIV_W = 21;

    localparam int U_HI_W  = CHANNEL_BITS - 1 + WB - FRAC_BITS + 1;
    localparam int U_NUM_W = U_HI_W + WB;
    localparam int U_Q_W   = U_NUM_W - SRGB_DIV_W + 1;
    localparam int ROOT_BITS = WB + 3;

    // Register stages inside each unit. The curve base takes two stages of
    // reciprocal multiplication.
    localparam int UDIV_LAT = 2;
    localparam int SRGB_LAT = UDIV_LAT + 3 * ROOT_BITS + 2;
    localparam int ADIV_Q_W = CHANNEL_BITS - 1;
    localparam int ADIV_LAT = ADIV_Q_W + 2;

    typedef struct packed {
        logic signed [CHANNEL_BITS-1:0] red_in;
        logic signed [CHANNEL_BITS-1:0] green_in;
        logic signed [CHANNEL_BITS-1:0] blue_in;
        logic signed [CHANNEL_BITS-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic signed [CHANNEL_BITS-1:0] red_out;
        logic signed [CHANNEL_BITS-1:0] green_out;
        logic signed [CHANNEL_BITS-1:0] blue_out;
        logic [ALPHA_BITS-1:0]          alpha_out;
    } pixel_out_t;

endpackage

// ===== rtl/plac_srgb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plac_srgb
// One channel of sRGB decode: linear toe by reciprocal multiply, power curve
// by reciprocal multiplication for the base, squaring and a bit-serial
// fifth-root search.
// ----------------------------------------------------------------------------
module plac_srgb
    import plac_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [CHANNEL_BITS-1:0] x,
    output logic [CHANNEL_BITS-2:0]        y
);

    localparam int X_W      = CHANNEL_BITS - 1;
    localparam int LIN_MAX  = (4045 * (1 << FRAC_BITS)) / 100000;
    localparam int LIN_W    = $clog2(LIN_MAX + 1);
    localparam int LIN_N_W  = $clog2(LIN_MAX * 100 + 646 + 1);
    localparam int LIN_SH   = 32;
    localparam int LIN_R_W  = LIN_SH - 10;
    localparam longint unsigned LIN_RECIP = ((64'd1 << LIN_SH) + 64'd1291) / 64'd1292;
    localparam int LIN_P_W  = LIN_N_W + LIN_R_W;
    localparam int LQ_W     = LIN_P_W - LIN_SH;

    // The divisor 1.055 in Q.20 is eight times an odd number, so the rounded
    // quotient is a floor division by that odd number, done by reciprocal.
    localparam int DIV_ODD   = SRGB_DIV / 8;
    localparam int HALF_ODD  = SRGB_DIV / 16;
    localparam int NUM_SH    = WB - 3;
    localparam int RCP_SH    = 59;
    localparam int RCP_LO_W  = 21;
    localparam longint unsigned RCP =
        ((64'd1 << RCP_SH) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD);
    localparam longint unsigned RCP_HI = RCP >> RCP_LO_W;
    localparam longint unsigned RCP_LO = RCP & ((64'd1 << RCP_LO_W) - 64'd1);
    localparam longint unsigned RCP_C  = (64'(HALF_ODD) * RCP) >> NUM_SH;
    localparam int PH_W      = U_HI_W + RCP_LO_W;
    localparam int PL_W      = PH_W + 1;
    localparam int PS_W      = PH_W + RCP_LO_W + 1;
    localparam int U_SH      = RCP_SH - NUM_SH;

    localparam int V_W   = 2 * U_Q_W - WB;
    localparam int S_W   = ROOT_BITS;
    localparam int S2_W  = 2 * S_W - WB;
    localparam int S4_W  = 2 * S2_W - WB;
    localparam int P_W   = S4_W + S_W - WB;
    localparam int CMP_W = (P_W > V_W) ? P_W : V_W;
    localparam int F_W   = V_W + S_W;
    localparam int F_SH  = 2 * WB - FRAC_BITS;
    localparam int RT_N  = 3 * ROOT_BITS;
    localparam int SIDE_N = SRGB_LAT - 1;

    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_LIN   = 2'd1;
    localparam logic [1:0] MODE_CURVE = 2'd2;

    typedef struct packed {
        logic [1:0]      mode;
        logic [LQ_W-1:0] lin;
    } side_t;

    typedef struct packed {
        logic [V_W-1:0]  v;
        logic [S_W-1:0]  s;
        logic [S_W-1:0]  c;
        logic [S2_W-1:0] s2;
        logic [S4_W-1:0] s4;
        logic            usat;
    } root_t;

    side_t                  side0;
    side_t                  side_reg [SIDE_N];
    logic [U_HI_W-1:0]      hi;
    logic [LIN_N_W-1:0]     lin_n;
    logic [LIN_P_W-1:0]     lin_p;
    logic [PH_W-1:0]        ph_next;
    logic [PH_W-1:0]        ph_reg;
    logic [PL_W-1:0]        pl_next;
    logic [PL_W-1:0]        pl_reg;
    logic [PS_W-1:0]        psum;
    logic [U_Q_W-1:0]       u_next;
    logic [U_Q_W-1:0]       u_reg;
    logic [U_Q_W-1:0]       u;
    logic [2*U_Q_W-1:0]     uu;
    root_t                  rt0;
    root_t                  rt_reg  [RT_N+1];
    root_t                  rt_next [RT_N];
    logic [F_W-1:0]         fprod;
    logic [F_W-F_SH-1:0]    r;
    side_t                  side_f;
    logic [X_W-1:0]         y_next;
    logic [X_W-1:0]         y_reg;

    // Classify the input and form the two partial products of the base.
    always_comb
    begin
        lin_n = LIN_N_W'(x[LIN_W-1:0]) * LIN_N_W'(100) + LIN_N_W'(646);
        lin_p = LIN_P_W'(lin_n) * LIN_P_W'(LIN_RECIP);
        side0.lin = lin_p[LIN_P_W-1:LIN_SH];
        if (x[CHANNEL_BITS-1] || (x == '0))
            side0.mode = MODE_ZERO;
        else if (x[X_W-1:0] <= X_W'(LIN_MAX))
            side0.mode = MODE_LIN;
        else
            side0.mode = MODE_CURVE;
        hi      = (U_HI_W'(x[X_W-1:0]) << (WB - FRAC_BITS)) + U_HI_W'(SRGB_OFF);
        ph_next = PH_W'(hi) * PH_W'(RCP_HI);
        pl_next = PL_W'(hi) * PL_W'(RCP_LO) + PL_W'(RCP_C);
    end

    // Sum of the partial products; the quotient sits in the upper bits.
    always_comb
    begin
        psum   = (PS_W'(ph_reg) << RCP_LO_W) + PS_W'(pl_reg);
        u_next = psum[U_SH +: U_Q_W];
    end

    // Square of the base.
    always_comb
    begin
        u  = u_reg;
        uu = (2*U_Q_W)'(u) * (2*U_Q_W)'(u) + (2*U_Q_W)'(64'd1 << (WB - 1));
        rt0.v    = uu[2*U_Q_W-1:WB];
        rt0.s    = '0;
        rt0.c    = '0;
        rt0.s2   = '0;
        rt0.s4   = '0;
        rt0.usat = (64'(u) >= (64'd1 << (WB + 7)));
    end

    // Fifth-root search: each result bit takes three multiply stages.
    for (genvar j = 0; j < RT_N; j++)
    begin : g_root
        localparam int PH  = j % 3;
        localparam int BIT = ROOT_BITS - 1 - j / 3;
        if (PH == 0)
        begin : g_sq
            logic [S_W-1:0]   cand;
            logic [2*S_W-1:0] sq;
            always_comb
            begin
                cand = rt_reg[j].s | (S_W'(1) << BIT);
                sq   = (2*S_W)'(cand) * (2*S_W)'(cand);
                rt_next[j]    = rt_reg[j];
                rt_next[j].c  = cand;
                rt_next[j].s2 = sq[2*S_W-1:WB];
            end
        end
        else if (PH == 1)
        begin : g_quad
            logic [2*S2_W-1:0] q4;
            always_comb
            begin
                q4 = (2*S2_W)'(rt_reg[j].s2) * (2*S2_W)'(rt_reg[j].s2);
                rt_next[j]    = rt_reg[j];
                rt_next[j].s4 = q4[2*S2_W-1:WB];
            end
        end
        else
        begin : g_fifth
            logic [S4_W+S_W-1:0] q5;
            logic [P_W-1:0]      p;
            always_comb
            begin
                q5 = (S4_W+S_W)'(rt_reg[j].s4) * (S4_W+S_W)'(rt_reg[j].c);
                p  = q5[S4_W+S_W-1:WB];
                rt_next[j] = rt_reg[j];
                if (CMP_W'(p) <= CMP_W'(rt_reg[j].v))
                    rt_next[j].s = rt_reg[j].c;
            end
        end
    end

    // Result is v * s, rounded back to the channel format.
    always_comb
    begin
        side_f = side_reg[SIDE_N-1];
        fprod  = F_W'(rt_reg[RT_N].v) * F_W'(rt_reg[RT_N].s)
               + F_W'(64'd1 << (F_SH - 1));
        r      = fprod[F_W-1:F_SH];
        case (side_f.mode)
            MODE_LIN:
                y_next = X_W'(side_f.lin);
            MODE_CURVE:
            begin
                if (rt_reg[RT_N].usat || (64'(r) > ((64'd1 << X_W) - 64'd1)))
                    y_next = '1;
                else
                    y_next = X_W'(r);
            end
            default:
                y_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side0;
            for (int k = 1; k < SIDE_N; k++)
                side_reg[k] <= side_reg[k-1];
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            u_reg  <= u_next;
            rt_reg[0] <= rt0;
            for (int k = 0; k < RT_N; k++)
                rt_reg[k+1] <= rt_next[k];
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/plac_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plac_div
// One channel of colour divided by alpha, rounded half away from zero and
// saturated, as a restoring divider with one quotient bit per stage.
// ----------------------------------------------------------------------------
module plac_div
    import plac_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [CHANNEL_BITS-1:0] c,
    input  logic [ALPHA_BITS-1:0]          a,
    output logic signed [CHANNEL_BITS-1:0] q
);

    localparam int NUM_W = CHANNEL_BITS + FRAC_BITS;

    typedef struct packed {
        logic [ALPHA_BITS-1:0] rem;
        logic [ADIV_Q_W-1:0]   lo;
        logic [ALPHA_BITS-1:0] a;
        logic                  neg;
        logic                  ovf;
    } dv_t;

    logic [CHANNEL_BITS-1:0] mag;
    logic [NUM_W-1:0]        num;
    dv_t                     dv0;
    dv_t                     dv_reg  [ADIV_Q_W+1];
    dv_t                     dv_next [ADIV_Q_W];
    logic [CHANNEL_BITS-1:0] qx;
    logic [CHANNEL_BITS-1:0] q_next;
    logic [CHANNEL_BITS-1:0] q_reg;

    // A quotient of 2^15 or more overflows, which shows in the top bits alone.
    always_comb
    begin
        mag = c[CHANNEL_BITS-1] ? CHANNEL_BITS'(-c) : CHANNEL_BITS'(c);
        num = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(a >> 1);
        dv0.rem = num[NUM_W-1:ADIV_Q_W];
        dv0.lo  = num[ADIV_Q_W-1:0];
        dv0.a   = a;
        dv0.neg = c[CHANNEL_BITS-1];
        dv0.ovf = (num[NUM_W-1:ADIV_Q_W] >= a);
    end

    for (genvar k = 0; k < ADIV_Q_W; k++)
    begin : g_step
        logic [ALPHA_BITS:0] trial;
        logic                ge;
        always_comb
        begin
            trial = {dv_reg[k].rem, dv_reg[k].lo[ADIV_Q_W-1]};
            ge    = (trial >= (ALPHA_BITS+1)'(dv_reg[k].a));
            dv_next[k]     = dv_reg[k];
            dv_next[k].rem = ge ? ALPHA_BITS'(trial - (ALPHA_BITS+1)'(dv_reg[k].a))
                                : ALPHA_BITS'(trial);
            dv_next[k].lo  = {dv_reg[k].lo[ADIV_Q_W-2:0], ge};
        end
    end

    always_comb
    begin
        qx = {1'b0, dv_reg[ADIV_Q_W].lo};
        if (dv_reg[ADIV_Q_W].ovf)
            q_next = dv_reg[ADIV_Q_W].neg ? {1'b1, {(CHANNEL_BITS-1){1'b0}}}
                                          : {1'b0, {(CHANNEL_BITS-1){1'b1}}};
        else
            q_next = dv_reg[ADIV_Q_W].neg ? -qx : qx;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv0;
            for (int k = 0; k < ADIV_Q_W; k++)
                dv_reg[k+1] <= dv_next[k];
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/pixel_linearize_and_alpha_convert_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_linearize_and_alpha_convert_unit
// RGBA pixel converter: sRGB decode, premultiply or unpremultiply by alpha.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while the output is not stalled. The
// pipeline depth is set by the sRGB power curve: a two-stage reciprocal
// multiply for the curve base followed by a fifth-root search of three
// multiply stages per result bit. All stages advance together, so a stall at
// the output holds the whole pipeline and in_ready drops in the same cycle.
// Configuration is taken at any time on its own channel but must only change
// while no pixel is in flight.
module pixel_linearize_and_alpha_convert_unit
    import plac_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  pixel_in_t                 in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output pixel_out_t                out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int LAT = SRGB_LAT;
    localparam int PAD = SRGB_LAT - ADIV_LAT;
    localparam int CH  = CHANNEL_BITS;
    localparam int PM_W = CH + ALPHA_BITS + 1;

    typedef logic [2:0][CH-1:0] rgb_t;

    typedef struct packed {
        rgb_t                  col;
        rgb_t                  pm;
        logic [ALPHA_BITS-1:0] a;
    } pass_t;

    function automatic logic [CH-1:0] premul(input logic signed [CH-1:0] cv,
                                             input logic [ALPHA_BITS-1:0] av);
        logic signed [PM_W-1:0] prod;
        logic [PM_W-1:0]        pmag;
        logic [PM_W-1:0]        rsum;
        logic [CH-1:0]          pq;
        prod = PM_W'(cv) * $signed(PM_W'(av));
        pmag = prod[PM_W-1] ? PM_W'(-prod) : PM_W'(prod);
        rsum = pmag + PM_W'(ALPHA_ONE / 2);
        pq   = rsum[CH+FRAC_BITS-1:FRAC_BITS];
        return prod[PM_W-1] ? -pq : pq;
    endfunction

    logic [1:0]            op_reg;
    logic                  srgb_reg;
    logic                  prem_reg;
    logic                  en;
    logic [LAT-1:0]        vld_reg;
    logic                  out_valid_reg;
    pixel_out_t            out_data_reg;
    pixel_out_t            sel;
    rgb_t                  in_col;
    logic [ALPHA_BITS-1:0] a_clamp;
    pass_t                 pass0;
    pass_t                 pass_reg [LAT];
    rgb_t                  div_q;
    rgb_t                  pad_reg [PAD];
    logic [2:0][CH-2:0]    srgb_y;
    pass_t                 pf;
    rgb_t                  sel_col;
    logic [ALPHA_BITS-1:0] sel_a;
    logic                  zero;

    // The whole pipeline moves only when the output register can take a transfer.
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_col[0] = in_data.red_in;
        in_col[1] = in_data.green_in;
        in_col[2] = in_data.blue_in;
        if (in_data.alpha_in[CH-1])
            a_clamp = '0;
        else if ($unsigned(in_data.alpha_in) > CH'(ALPHA_ONE))
            a_clamp = ALPHA_BITS'(ALPHA_ONE);
        else
            a_clamp = ALPHA_BITS'(in_data.alpha_in);
        pass0.col = in_col;
        pass0.a   = a_clamp;
        for (int i = 0; i < 3; i++)
            pass0.pm[i] = premul($signed(in_col[i]), a_clamp);
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_ch
        plac_srgb u_srgb
        (
            .clk (clk),
            .en  (en),
            .x   ($signed(in_col[i])),
            .y   (srgb_y[i])
        );

        plac_div u_div
        (
            .clk (clk),
            .en  (en),
            .c   ($signed(in_col[i])),
            .a   (a_clamp),
            .q   (div_q[i])
        );
    end

    always_comb
    begin
        pf      = pass_reg[LAT-1];
        sel_col = pf.col;
        sel_a   = pf.a;
        zero    = 1'b0;
        case (op_reg)
            OP_TO_PREMUL:
            begin
                if (pf.a == '0)
                    zero = 1'b1;
                else if (!prem_reg)
                    sel_col = pf.pm;
            end
            OP_TO_STRAIGHT:
            begin
                if (prem_reg)
                begin
                    if (pf.a == '0)
                        zero = 1'b1;
                    else
                        sel_col = pad_reg[PAD-1];
                end
            end
            OP_LINEARIZE:
            begin
                if (srgb_reg)
                    for (int i = 0; i < 3; i++)
                        sel_col[i] = {1'b0, srgb_y[i]};
            end
            default:
            begin
            end
        endcase
        if (zero)
        begin
            sel_col = '0;
            sel_a   = '0;
        end
        sel.red_out   = sel_col[0];
        sel.green_out = sel_col[1];
        sel.blue_out  = sel_col[2];
        sel.alpha_out = sel_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_LINEARIZE;
            srgb_reg <= 1'b0;
            prem_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_OPERATION:      op_reg   <= cfg_data[1:0];
                REG_INPUT_IS_SRGB:  srgb_reg <= cfg_data[0];
                REG_SOURCE_IS_PREM: prem_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_reg[0] <= pass0;
            for (int k = 1; k < LAT; k++)
                pass_reg[k] <= pass_reg[k-1];
            pad_reg[0] <= div_q;
            for (int k = 1; k < PAD; k++)
                pad_reg[k] <= pad_reg[k-1];
            out_data_reg <= sel;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.alpha_out <= ALPHA_BITS'(ALPHA_ONE))
        else $error("alpha result above one");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the output is blocked");

    a_premul_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-1] && op_reg == OP_TO_PREMUL && pf.a == '0 |=>
        out_data.alpha_out == '0 && out_data.red_out == '0 &&
        out_data.green_out == '0 && out_data.blue_out == '0)
        else $error("zero alpha premultiply did not give transparent black");

endmodule

// ===== dv/tb_pixel_linearize_and_alpha_convert_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_linearize_and_alpha_convert_unit
// Self-checking bench for the pixel linearize and alpha convert unit. Pixels
// are streamed under random source gaps and sink stalls through a series of
// register settings. Every accepted pixel is run through an in-bench model of
// the sRGB decode, premultiply and unpremultiply paths. The outputs are then
// checked in order against those predictions.
// ----------------------------------------------------------------------------
module tb_pixel_linearize_and_alpha_convert_unit;
    import plac_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    pixel_in_t  in_data;
    logic       out_valid;
    logic       out_ready;
    pixel_out_t out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    pixel_in_t  pending_pixels[$];
    pixel_out_t expected_pixels[$];

    logic [1:0] cur_operation;
    logic       cur_srgb;
    logic       cur_premul;
    bit         steady_flow;

    int mismatch_count;
    int pixels_checked;
    int src_gap;
    int sink_stall;
    int pixels_per_op[4];

    pixel_linearize_and_alpha_convert_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Round to nearest, ties away from zero.
    function automatic longint div_nearest(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clip_channel(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint unsigned fifth_power(longint unsigned s);
        longint unsigned s2;
        longint unsigned s4;
        s2 = (s * s) >> WB;
        s4 = (s2 * s2) >> WB;
        return (s4 * s) >> WB;
    endfunction

    function automatic longint decode_srgb(longint x);
        longint unsigned u;
        longint unsigned v;
        longint unsigned s;
        longint unsigned cand;
        longint unsigned r;
        if (x <= 0)
            return 0;
        if (longint'(x) * 100000 <= (longint'(4045) << FRAC_BITS))
            return clip_channel(div_nearest(x * 100, 1292));
        u = ((((longint'(x) << (WB - FRAC_BITS)) + SRGB_OFF) << WB) + SRGB_DIV / 2) / SRGB_DIV;
        if (u >= (64'd1 << (WB + 7)))
            return 32767;
        v = (u * u + (64'd1 << (WB - 1))) >> WB;
        s = 0;
        // Bitwise search for the fifth root of v.
        for (int b = WB + 2; b >= 0; b--)
        begin
            cand = s | (64'd1 << b);
            if (fifth_power(cand) <= v)
                s = cand;
        end
        r = (v * s + (64'd1 << (2 * WB - FRAC_BITS - 1))) >> (2 * WB - FRAC_BITS);
        if (r > 32767)
            return 32767;
        return longint'(r);
    endfunction

    function automatic pixel_out_t convert_pixel(pixel_in_t p);
        longint     ch[3];
        longint     a;
        bit         zero;
        pixel_out_t r;
        zero  = 1'b0;
        ch[0] = p.red_in;
        ch[1] = p.green_in;
        ch[2] = p.blue_in;
        a     = p.alpha_in;
        if (a < 0)
            a = 0;
        if (a > ALPHA_ONE)
            a = ALPHA_ONE;
        if (cur_operation == OP_TO_PREMUL)
        begin
            if (a == 0)
                zero = 1'b1;
            else if (!cur_premul)
                for (int i = 0; i < 3; i++)
                    ch[i] = clip_channel(div_nearest(ch[i] * a, ALPHA_ONE));
        end
        else if (cur_operation == OP_TO_STRAIGHT)
        begin
            if (cur_premul)
            begin
                if (a == 0)
                    zero = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                        ch[i] = clip_channel(div_nearest(ch[i] * ALPHA_ONE, a));
            end
        end
        else if (cur_operation == OP_LINEARIZE && cur_srgb)
        begin
            for (int i = 0; i < 3; i++)
                ch[i] = decode_srgb(ch[i]);
        end
        if (zero)
        begin
            ch[0] = 0;
            ch[1] = 0;
            ch[2] = 0;
            a     = 0;
        end
        r.red_out   = ch[0][CHANNEL_BITS-1:0];
        r.green_out = ch[1][CHANNEL_BITS-1:0];
        r.blue_out  = ch[2][CHANNEL_BITS-1:0];
        r.alpha_out = a[ALPHA_BITS-1:0];
        return r;
    endfunction

    // Mostly short idles, a few long ones; none during steady stretches.
    function automatic int pick_idle();
        int sel;
        sel = $urandom_range(0, 99);
        if (steady_flow || sel < 55)
            return 0;
        if (sel < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'($urandom_range(0, 4400));
            2: return 16'($urandom_range(0, 200));
            3: return 16'(int'($urandom_range(0, 400)) - 200);
            4: return 16'($urandom_range(4000, 32767));
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'h7fff;
                    1: return 16'h8000;
                    2: return 16'd165;
                    3: return 16'd166;
                    default: return 16'd4096;
                endcase
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_alpha();
        case ($urandom_range(0, 5))
            0: return 16'($urandom());
            1: return 16'd0;
            2: return 16'd4096;
            3: return 16'($urandom_range(1, 64));
            default: return 16'($urandom_range(0, 4097));
        endcase
    endfunction

    function automatic pixel_in_t make_pixel(logic [15:0] r, logic [15:0] g,
                                             logic [15:0] b, logic [15:0] a);
        pixel_in_t p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.alpha_in = a;
        return p;
    endfunction

    // Source: a transfer happens at any edge with valid and ready high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(convert_pixel(in_data));
                pixels_per_op[cur_operation]++;
            end
            if (!in_valid || in_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_pixels.size() > 0)
                begin
                    in_data  <= pending_pixels.pop_front();
                    in_valid <= 1'b1;
                    src_gap  = pick_idle();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Sink: random back-pressure and in-order compare.
    always @(posedge clk or negedge rst_n)
    begin
        pixel_out_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output pixel %h", out_data);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    pixels_checked++;
                    if (out_data.red_out !== want.red_out
                        || out_data.green_out !== want.green_out
                        || out_data.blue_out !== want.blue_out
                        || out_data.alpha_out !== want.alpha_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                                     want.red_out, want.green_out, want.blue_out,
                                     want.alpha_out, out_data.red_out,
                                     out_data.green_out, out_data.blue_out,
                                     out_data.alpha_out);
                    end
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready  <= 1'b1;
                sink_stall = pick_idle();
            end
        end
    end

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_OPERATION)
            cur_operation = value;
        else if (idx == REG_INPUT_IS_SRGB)
            cur_srgb = value[0];
        else if (idx == REG_SOURCE_IS_PREM)
            cur_premul = value[0];
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0);
    endtask

    initial
    begin
        logic [1:0] phase_op[8];
        bit         phase_srgb[8];
        bit         phase_prem[8];
        logic [15:0] corner[6];
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_OPERATION;
        cfg_data      = '0;
        cur_operation = OP_LINEARIZE;
        cur_srgb      = 1'b0;
        cur_premul    = 1'b0;
        steady_flow   = 1'b0;
        phase_op   = '{OP_LINEARIZE, OP_LINEARIZE, OP_TO_PREMUL, OP_TO_PREMUL,
                       OP_TO_STRAIGHT, OP_TO_STRAIGHT, 2'd3, OP_LINEARIZE};
        phase_srgb = '{0, 1, 0, 1, 0, 0, 1, 1};
        phase_prem = '{0, 0, 0, 1, 1, 0, 1, 1};
        corner     = '{16'h0000, 16'h7fff, 16'h8000, 16'd4096, 16'd165, 16'hffff};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The first phase runs on reset values of the registers.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                write_register(REG_OPERATION, phase_op[ph]);
                write_register(REG_INPUT_IS_SRGB, {1'($urandom()), phase_srgb[ph]});
                write_register(REG_SOURCE_IS_PREM, {1'($urandom()), phase_prem[ph]});
            end
            steady_flow = (ph % 3 == 1);
            if (ph < 3)
                for (int k = 0; k < 6; k++)
                    pending_pixels.push_back(make_pixel(corner[k], corner[(k + 1) % 6],
                                                        corner[(k + 2) % 6],
                                                        corner[(k + 3) % 6]));
            pending_pixels.push_back(make_pixel(16'd4096, 16'h8000, 16'd166, 16'd0));
            pending_pixels.push_back(make_pixel(16'h7fff, 16'd1, 16'hffff, 16'd4097));
            pending_pixels.push_back(make_pixel(16'd2048, 16'h7fff, 16'h8000, 16'd1));
            for (int k = 0; k < 100; k++)
            begin
                if (k == 50)
                    steady_flow = ~steady_flow;
                pending_pixels.push_back(make_pixel(pick_channel(), pick_channel(),
                                                    pick_channel(), pick_alpha()));
            end
            wait_drained();
        end

        repeat (150) @(posedge clk);
        $display("checked %0d pixels over eight register settings", pixels_checked);
        $display("per operation: linearize %0d, premultiply %0d, straight %0d, unused code %0d",
                 pixels_per_op[0], pixels_per_op[1], pixels_per_op[2], pixels_per_op[3]);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
